/* sv/rotm_pkg.sv */
// ----------------------------------------------------------------------------
// rotm_pkg
// Shared types and constants of the axis-angle to rotation matrix block.
// ----------------------------------------------------------------------------
package rotm_pkg;

    localparam int ATAN_LEN = 24;
    localparam int XW       = 33;   // CORDIC x/y/z width, Q30
    localparam int KW       = 16;   // axis component width
    localparam int OW       = 18;   // matrix entry width
    localparam int NE       = 9;    // matrix entries

    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30     = 33'sd1073741824;

    localparam logic signed [XW-1:0] ATAN_TURNS [ATAN_LEN] = '{
        33'h020000000, 33'h012E4051E, 33'h009FB385B, 33'h0051111D4,
        33'h0028B0D43, 33'h00145D7E1, 33'h000A2F61E, 33'h000517C55,
        33'h00028BE53, 33'h000145F2F, 33'h0000A2F98, 33'h0000517CC,
        33'h000028BE6, 33'h0000145F3, 33'h00000A2FA, 33'h00000517D,
        33'h0000028BE, 33'h00000145F, 33'h000000A30, 33'h000000518,
        33'h00000028C, 33'h000000146, 33'h0000000A3, 33'h000000051
    };

    typedef enum logic [1:0] {SG_NONE, SG_PLUS, SG_MINUS} t_sgn;

    // quadratic terms: 0 xx, 1 yy, 2 zz, 3 xy, 4 xz, 5 yz
    // sine terms:      0 x,  1 y,  2 z
    localparam logic [2:0] ENT_QUAD [NE] = '{3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd5,
                                              3'd4, 3'd5, 3'd2};
    localparam logic [1:0] ENT_SIN  [NE] = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0,
                                              2'd1, 2'd0, 2'd0};
    localparam t_sgn       ENT_SGN  [NE] = '{SG_NONE, SG_MINUS, SG_PLUS,
                                              SG_PLUS, SG_NONE, SG_MINUS,
                                              SG_MINUS, SG_PLUS, SG_NONE};
    localparam logic       ENT_DIAG [NE] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                              1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic [1:0]           quad;
        logic signed [KW-1:0] kx;
        logic signed [KW-1:0] ky;
        logic signed [KW-1:0] kz;
    } t_cordic;

endpackage

/* sv/rotm_cordic_stage.sv */
// ----------------------------------------------------------------------------
// rotm_cordic_stage
// One registered CORDIC rotation step with its own valid and backpressure.
// ----------------------------------------------------------------------------
module rotm_cordic_stage import rotm_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cordic i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cordic o_data
);

    localparam logic [4:0] IDX = STEP[4:0];

    logic    r_v;
    t_cordic r_d;
    t_cordic n_d;
    logic    w_en;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        n_d = i_data;
        if (!i_data.z[XW-1]) begin
            n_d.x = i_data.x - (i_data.y >>> STEP);
            n_d.y = i_data.y + (i_data.x >>> STEP);
            n_d.z = i_data.z - ATAN_TURNS[IDX];
        end else begin
            n_d.x = i_data.x + (i_data.y >>> STEP);
            n_d.y = i_data.y - (i_data.x >>> STEP);
            n_d.z = i_data.z + ATAN_TURNS[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
        if (w_en) begin
            r_d <= n_d;
        end
    end

endmodule

/* sv/rotm_rodrigues.sv */
// ----------------------------------------------------------------------------
// rotm_rodrigues
// Quadrant mapping and Rodrigues' formula in four register stages:
// products, quadratic terms, sums, rounding with saturation.
// ----------------------------------------------------------------------------
module rotm_rodrigues import rotm_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_cordic              i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [OW-1:0] o_ent [NE]
);

    localparam int PKW = 2 * KW;          // ka*kb
    localparam int PW  = PKW + XW;        // ka*kb*vt
    localparam int SW  = KW + XW;         // kc*sin
    localparam int AW  = PW + 2;          // accumulator
    localparam int RW  = AW + 1 - 30;     // after final shift
    localparam logic signed [PW:0]  HALF_F = (PW+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [AW:0]  HALF_O = (AW+1)'(1) <<< 29;
    localparam logic signed [RW-1:0] SAT_HI = RW'(131071);
    localparam logic signed [RW-1:0] SAT_LO = -RW'(131072);

    logic [3:0] r_v;
    logic [3:0] w_en;

    assign w_en[3]  = !r_v[3] || i_ready;
    assign w_en[2]  = !r_v[2] || w_en[3];
    assign w_en[1]  = !r_v[1] || w_en[2];
    assign w_en[0]  = !r_v[0] || w_en[1];
    assign o_ready  = w_en[0];
    assign o_valid  = r_v[3];

    // stage 0: quadrant map, products
    logic signed [XW-1:0]  n_c, n_s;
    logic signed [XW-1:0]  r_c0, r_vt;
    logic signed [PKW-1:0] r_kk [6];
    logic signed [SW-1:0]  r_ks0 [3];

    always_comb begin
        case (i_data.quad)
            2'd0:    begin n_c = i_data.x;  n_s = i_data.y;  end
            2'd1:    begin n_c = -i_data.y; n_s = i_data.x;  end
            2'd2:    begin n_c = -i_data.x; n_s = -i_data.y; end
            default: begin n_c = i_data.y;  n_s = -i_data.x; end
        endcase
    end

    // stage 1: quadratic terms
    logic signed [PW-1:0] r_q [6];
    logic signed [XW-1:0] r_c1;
    logic signed [SW-1:0] r_ks1 [3];

    // stage 2: sums
    logic signed [PW:0]   w_qr [6];
    logic signed [PW-1:0] w_t  [6];
    logic signed [AW-1:0] n_acc [NE];
    logic signed [AW-1:0] r_acc [NE];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_qr[i] = $signed({r_q[i][PW-1], r_q[i]}) + HALF_F;
            w_t[i]  = PW'(w_qr[i] >>> FRAC_BITS);
        end
        for (int e = 0; e < NE; e++) begin
            n_acc[e] = AW'(w_t[ENT_QUAD[e]]);
            case (ENT_SGN[e])
                SG_PLUS:  n_acc[e] = n_acc[e] + AW'(r_ks1[ENT_SIN[e]]);
                SG_MINUS: n_acc[e] = n_acc[e] - AW'(r_ks1[ENT_SIN[e]]);
                default:  n_acc[e] = n_acc[e];
            endcase
            if (ENT_DIAG[e]) begin
                n_acc[e] = n_acc[e] + (AW'(r_c1) <<< FRAC_BITS);
            end
        end
    end

    // stage 3: round and saturate
    logic signed [AW:0]   w_ar [NE];
    logic signed [RW-1:0] w_r  [NE];
    logic signed [OW-1:0] n_ent [NE];
    logic signed [OW-1:0] r_ent [NE];

    always_comb begin
        for (int e = 0; e < NE; e++) begin
            w_ar[e] = $signed({r_acc[e][AW-1], r_acc[e]}) + HALF_O;
            w_r[e]  = RW'(w_ar[e] >>> 30);
            if (w_r[e] > SAT_HI) begin
                n_ent[e] = OW'(SAT_HI);
            end else if (w_r[e] < SAT_LO) begin
                n_ent[e] = OW'(SAT_LO);
            end else begin
                n_ent[e] = OW'(w_r[e]);
            end
        end
    end

    assign o_ent = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
        end
        if (w_en[0]) begin
            r_c0     <= n_c;
            r_vt     <= ONE_Q30 - n_c;
            r_kk[0]  <= i_data.kx * i_data.kx;
            r_kk[1]  <= i_data.ky * i_data.ky;
            r_kk[2]  <= i_data.kz * i_data.kz;
            r_kk[3]  <= i_data.kx * i_data.ky;
            r_kk[4]  <= i_data.kx * i_data.kz;
            r_kk[5]  <= i_data.ky * i_data.kz;
            r_ks0[0] <= i_data.kx * n_s;
            r_ks0[1] <= i_data.ky * n_s;
            r_ks0[2] <= i_data.kz * n_s;
        end
        if (w_en[1]) begin
            for (int i = 0; i < 6; i++) r_q[i] <= r_kk[i] * r_vt;
            r_c1  <= r_c0;
            r_ks1 <= r_ks0;
        end
        if (w_en[2]) r_acc <= n_acc;
        if (w_en[3]) r_ent <= n_ent;
    end

endmodule

/* sv/axis_angle_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Rotation matrix from an axis and a binary angle; the block does not normalize the axis.
// ----------------------------------------------------------------------------
// Accepts one word per cycle while no stage is held by backpressure and gives one matrix word per input word.
// The pipeline has one register per CORDIC step,
// then products, quadratic terms, sums and rounding each take one register.
// Every stage holds on backpressure independently, so bubbles are squeezed.
module axis_angle_to_rotation_matrix import rotm_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // axis_x, axis_y, axis_z, turn_angle
    input  logic [63:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
    output logic [167:0] o_m_axis_tdata
);

    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    t_cordic w_d [STEPS+1];
    logic    w_v [STEPS+1];
    logic    w_r [STEPS+1];
    logic signed [OW-1:0] w_ent [NE];

    assign w_v[0]          = i_s_axis_tvalid;
    assign o_s_axis_tready = w_r[0];

    always_comb begin
        w_d[0].x    = CORDIC_GAIN;
        w_d[0].y    = '0;
        w_d[0].z    = $signed({3'b000, i_s_axis_tdata[61:48], 16'h0000});
        w_d[0].quad = i_s_axis_tdata[63:62];
        w_d[0].kx   = i_s_axis_tdata[15:0];
        w_d[0].ky   = i_s_axis_tdata[31:16];
        w_d[0].kz   = i_s_axis_tdata[47:32];
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        rotm_cordic_stage #(.STEP(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    rotm_rodrigues #(.FRAC_BITS(FRAC_BITS)) u_rod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[STEPS]),
        .o_ready (w_r[STEPS]),
        .i_data  (w_d[STEPS]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_ent   (w_ent)
    );

    always_comb begin
        o_m_axis_tdata = '0;
        for (int e = 0; e < NE; e++) begin
            o_m_axis_tdata[e*OW +: OW] = w_ent[e];
        end
    end

`ifndef NO_ASSERTIONS
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> w_v[1])
        else $error("accepted word did not enter the first stage");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("pipeline stalled while output is taken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[1] && !w_r[1]) |=> (w_v[1] && $stable(w_d[1])))
        else $error("stalled first stage lost its word");
`endif

endmodule
